// ----- rtl/minv_pkg.sv -----
// Shared constants and index tables for the 4x4 cofactor matrix inverse.
package minv_pkg;

  // Default element format: signed Q16.16
  localparam int ELEMENT_WIDTH = 32;
  localparam int FRAC_BITS     = 16;

  // Limb width of the shared multiplier's wide operand
  localparam int LIMB_W = 32;

  // Width of the singularity tolerance register
  localparam int TOL_W = 31;

  // Last of the six permutation terms of a 3x3 determinant
  localparam logic [2:0] TERM_LAST = 3'd5;

  // Column choice (within the 3x3 minor) for rows 0..2 of each permutation
  // term; row 0 sits in bits [1:0].
  function automatic logic [5:0] perm_cols(input logic [2:0] term);
    logic [5:0] cols;
    unique case (term)
      3'd0:    cols = {2'd2, 2'd1, 2'd0};
      3'd1:    cols = {2'd1, 2'd2, 2'd0};
      3'd2:    cols = {2'd2, 2'd0, 2'd1};
      3'd3:    cols = {2'd0, 2'd2, 2'd1};
      3'd4:    cols = {2'd1, 2'd0, 2'd2};
      3'd5:    cols = {2'd0, 2'd1, 2'd2};
      default: cols = '0;
    endcase
    return cols;
  endfunction

  // Odd permutations subtract
  function automatic logic perm_neg(input logic [2:0] term);
    return (term == 3'd1) || (term == 3'd2) || (term == 3'd5);
  endfunction

  // Map index n of a 3-element list to the 4-element index that skips s
  function automatic logic [1:0] skip_idx(input logic [1:0] n, input logic [1:0] s);
    return (n < s) ? n : n + 2'd1;
  endfunction

endpackage

// ----- rtl/minv_if.sv -----
// Valid/ready channel interfaces for matrix elements in and inverse results out.
interface minv_in_if #(
  parameter int EW = minv_pkg::ELEMENT_WIDTH
);
  logic          valid;
  logic          ready;
  logic [EW-1:0] matrix_element;

  modport source(output valid, output matrix_element, input ready);
  modport sink(input valid, input matrix_element, output ready);
endinterface

interface minv_out_if #(
  parameter int EW = minv_pkg::ELEMENT_WIDTH
);
  logic          valid;
  logic          ready;
  logic [EW-1:0] inverse_element;
  logic [3:0]    element_index;
  logic          last_result;
  logic          singular;
  logic          saturated;
  logic [EW-1:0] determinant_value;

  modport source(output valid, output inverse_element, output element_index,
                 output last_result, output singular, output saturated,
                 output determinant_value, input ready);
  modport sink(input valid, input inverse_element, input element_index,
               input last_result, input singular, input saturated,
               input determinant_value, output ready);
endinterface

// ----- rtl/matrix_inverse_4x4_core.sv -----
// Top level: 4x4 fixed-point matrix inverse by cofactors, memory based.
// Sixteen elements are taken one per cycle in row-major order into a 16-entry
// matrix memory. After the sixteenth request the block is busy: a sequencer
// reads the matrix memory and drives one shared multiplier (element by one
// 32-bit limb per cycle, NL = ceil((3*W+3)/32) limbs, 4 at W = 32) to form the
// sixteen exact 3x3 cofactors into a cofactor memory, then the determinant.
// Each inverse element then comes from a restoring divider that retires one
// quotient bit per cycle; a singular matrix skips the divider and gives a
// result per cycle while the output is not stalled. Results are rounded to
// nearest with ties away from zero and saturated. The next matrix may be
// loaded while the final result still waits in the output register.
// det_tolerance is written through cfg_we/cfg_wdata; the user must write it
// only while idle, as the block itself does not enforce this.
module matrix_inverse_4x4_core #(
  parameter int ELEMENT_WIDTH = minv_pkg::ELEMENT_WIDTH,
  parameter int FRAC_BITS     = minv_pkg::FRAC_BITS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [minv_pkg::TOL_W-1:0] cfg_wdata,
  minv_in_if.sink                    in_chan,
  minv_out_if.source                 out_chan
);

  localparam int E    = ELEMENT_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int LW   = minv_pkg::LIMB_W;
  localparam int TW   = minv_pkg::TOL_W;
  localparam int C3W  = 3 * E + 3;              // exact 3x3 cofactor
  localparam int AW   = 4 * E + 5;              // exact determinant / accumulator
  localparam int NL   = (C3W + LW - 1) / LW;    // limbs of wide operand
  localparam int WB   = NL * LW;
  localparam int LCW  = $clog2(NL);
  localparam int PPW  = E + LW + 1;             // one partial product
  localparam int XW   = C3W + 2 * F + 2;        // rounded dividend
  localparam int YW   = AW + E + 1;             // divisor at its top position
  localparam int VW   = ((XW > YW) ? XW : YW) + 1;
  localparam int SW   = $clog2(E + 1);
  localparam int TLW  = (AW > TW + 3 * F) ? AW : TW + 3 * F;

  localparam logic [E-1:0] MAXV   = {1'b0, {(E-1){1'b1}}};
  localparam logic [E-1:0] MINMAG = {1'b1, {(E-1){1'b0}}};

  typedef enum logic [18:0] {
    S_LOAD   = 19'h00001,
    S_T_RD   = 19'h00002,
    S_T_LD1  = 19'h00004,
    S_T_MUL1 = 19'h00008,
    S_T_RD2  = 19'h00010,
    S_T_LD2  = 19'h00020,
    S_T_MUL2 = 19'h00040,
    S_T_ACC  = 19'h00080,
    S_C_WR   = 19'h00100,
    S_D_RD   = 19'h00200,
    S_D_LD   = 19'h00400,
    S_D_MUL  = 19'h00800,
    S_D_ACC  = 19'h01000,
    S_D_ABS  = 19'h02000,
    S_D_RND  = 19'h04000,
    S_V_RD   = 19'h08000,
    S_V_PREP = 19'h10000,
    S_V_DIV  = 19'h20000,
    S_V_EMIT = 19'h40000
  } state_t;

  state_t         state_r, state_nxt;
  logic [3:0]     load_cnt_r;
  logic [3:0]     ci_r;          // cofactor / column / result index
  logic [2:0]     term_r;
  logic [LCW-1:0] limb_r;
  logic [SW-1:0]  st_r;
  logic [TW-1:0]  tol_r;
  logic           out_valid_r;

  // Datapath registers
  logic signed [E-1:0] opa_r;
  logic [WB-1:0]       opb_r;
  logic [AW-1:0]       prod_r;
  logic [AW-1:0]       acc_r;
  logic [AW-1:0]       det_abs_r;
  logic                det_neg_r;
  logic [E-1:0]        det_val_r;
  logic                det_clip_r;
  logic                sing_r;
  logic [VW-1:0]       rem_r;
  logic [VW-1:0]       dv_r;
  logic [E-1:0]        q_r;
  logic                neg_r;
  logic                ovf_r;

  // Output register
  logic [E-1:0] out_elem_r;
  logic [3:0]   out_idx_r;
  logic         out_last_r;
  logic         out_sing_r;
  logic         out_sat_r;
  logic [E-1:0] out_det_r;

  // Memories and their registered read data
  logic [E-1:0]   mat_mem [16];
  logic [C3W-1:0] cof_mem [16];
  logic [E-1:0]   mat_rd_a, mat_rd_b;
  logic [C3W-1:0] cof_rd;
  logic [3:0]     mat_ra, cof_ra;

  logic in_acc, emit_go, limb_last;

  assign in_acc    = in_chan.valid && in_chan.ready;
  assign in_chan.ready = (state_r == S_LOAD);
  assign limb_last = (limb_r == LCW'(NL - 1));
  assign emit_go   = (state_r == S_V_EMIT) && (!out_valid_r || out_chan.ready);

  // Element addresses of the current permutation term
  logic [1:0] cr, cc;
  logic [5:0] cols;
  logic [3:0] a0, a1, a2;
  assign cr   = ci_r[3:2];
  assign cc   = ci_r[1:0];
  assign cols = minv_pkg::perm_cols(term_r);
  assign a0 = {minv_pkg::skip_idx(2'd0, cr), minv_pkg::skip_idx(cols[1:0], cc)};
  assign a1 = {minv_pkg::skip_idx(2'd1, cr), minv_pkg::skip_idx(cols[3:2], cc)};
  assign a2 = {minv_pkg::skip_idx(2'd2, cr), minv_pkg::skip_idx(cols[5:4], cc)};

  always_comb begin
    priority if (state_r == S_T_RD2) begin
      mat_ra = a2;
    end else if (state_r == S_D_RD) begin
      mat_ra = {2'b00, cc};
    end else begin
      mat_ra = a0;
    end
  end

  // Result k reads cofactor (column, row): the adjugate is the transpose
  assign cof_ra = (state_r == S_D_RD) ? {2'b00, cc} : {ci_r[1:0], ci_r[3:2]};

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mat_mem[load_cnt_r] <= in_chan.matrix_element;
    end
    mat_rd_a <= mat_mem[mat_ra];
    mat_rd_b <= mat_mem[a1];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_C_WR) begin
      cof_mem[ci_r] <= acc_r[C3W-1:0];
    end
    cof_rd <= cof_mem[cof_ra];
  end

  // Shared multiplier: element times one limb, shifted into place
  logic [LW-1:0]      limb_bits;
  logic signed [LW:0] limb_ext;
  logic signed [PPW-1:0] pp;
  logic [AW-1:0]      pp_sh;
  assign limb_bits = opb_r[LW*limb_r +: LW];
  assign limb_ext  = {limb_last & limb_bits[LW-1], limb_bits};
  assign pp        = opa_r * limb_ext;
  assign pp_sh     = {{(AW-PPW){pp[PPW-1]}}, pp} << (LW * limb_r);

  logic term_neg;
  assign term_neg = minv_pkg::perm_neg(term_r) ^ cr[0] ^ cc[0];

  // Determinant rounding, saturation and singular test
  logic [AW:0]  rnd_sum, det_mag;
  logic         det_clip_c, sing_c;
  logic [E-1:0] det_val_c;
  always_comb begin
    rnd_sum = {1'b0, det_abs_r} + ((AW+1)'(1) << (3 * F - 1));
    det_mag = rnd_sum >> (3 * F);
    if (det_neg_r) begin
      det_clip_c = det_mag > (AW+1)'(MINMAG);
      det_val_c  = det_clip_c ? MINMAG : -det_mag[E-1:0];
    end else begin
      det_clip_c = det_mag > (AW+1)'(MAXV);
      det_val_c  = det_clip_c ? MAXV : det_mag[E-1:0];
    end
    sing_c = TLW'(det_abs_r) <= (TLW'(tol_r) << (3 * F));
  end

  // Divider prep: dividend 2*|cof|*2^(2F) + |det|, divisor 2*|det|
  logic [C3W-1:0] cof_abs;
  logic [VW-1:0]  x_c;
  logic           ge;
  assign cof_abs = cof_rd[C3W-1] ? -cof_rd : cof_rd;
  assign x_c     = (VW'(cof_abs) << (2 * F + 1)) + VW'(det_abs_r);
  assign ge      = rem_r >= dv_r;

  // Result element selection
  logic [E-1:0] res_val;
  logic         res_clip;
  always_comb begin
    priority if (sing_r) begin
      res_val  = '0;
      res_clip = 1'b0;
    end else if (ovf_r) begin
      res_val  = neg_r ? MINMAG : MAXV;
      res_clip = 1'b1;
    end else if (!neg_r) begin
      res_clip = q_r > MAXV;
      res_val  = res_clip ? MAXV : q_r;
    end else begin
      res_clip = q_r > MINMAG;
      res_val  = res_clip ? MINMAG : -q_r;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_LOAD:   if (in_acc && load_cnt_r == 4'd15) state_nxt = S_T_RD;
      S_T_RD:   state_nxt = S_T_LD1;
      S_T_LD1:  state_nxt = S_T_MUL1;
      S_T_MUL1: if (limb_last) state_nxt = S_T_RD2;
      S_T_RD2:  state_nxt = S_T_LD2;
      S_T_LD2:  state_nxt = S_T_MUL2;
      S_T_MUL2: if (limb_last) state_nxt = S_T_ACC;
      S_T_ACC:  state_nxt = (term_r == minv_pkg::TERM_LAST) ? S_C_WR : S_T_RD;
      S_C_WR:   state_nxt = (ci_r == 4'd15) ? S_D_RD : S_T_RD;
      S_D_RD:   state_nxt = S_D_LD;
      S_D_LD:   state_nxt = S_D_MUL;
      S_D_MUL:  if (limb_last) state_nxt = S_D_ACC;
      S_D_ACC:  state_nxt = (cc == 2'd3) ? S_D_ABS : S_D_RD;
      S_D_ABS:  state_nxt = S_D_RND;
      S_D_RND:  state_nxt = sing_c ? S_V_EMIT : S_V_RD;
      S_V_RD:   state_nxt = S_V_PREP;
      S_V_PREP: state_nxt = S_V_DIV;
      S_V_DIV:  if ((ge && st_r == '0) || st_r == SW'(E)) state_nxt = S_V_EMIT;
      S_V_EMIT: begin
        if (emit_go) begin
          priority if (ci_r == 4'd15) state_nxt = S_LOAD;
          else if (sing_r)            state_nxt = S_V_EMIT;
          else                        state_nxt = S_V_RD;
        end
      end
      default:  state_nxt = S_LOAD;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      load_cnt_r  <= '0;
      ci_r        <= '0;
      term_r      <= '0;
      limb_r      <= '0;
      st_r        <= '0;
      tol_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) tol_r <= cfg_wdata;
      if (in_acc) load_cnt_r <= load_cnt_r + 4'd1;
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_LOAD: begin
          if (in_acc && load_cnt_r == 4'd15) begin
            ci_r   <= '0;
            term_r <= '0;
          end
        end
        S_T_LD1, S_T_LD2, S_D_LD: limb_r <= '0;
        S_T_MUL1, S_T_MUL2, S_D_MUL: limb_r <= limb_r + LCW'(1);
        S_T_ACC: begin
          term_r <= (term_r == minv_pkg::TERM_LAST) ? 3'd0 : term_r + 3'd1;
        end
        S_C_WR:   ci_r <= ci_r + 4'd1;
        S_D_ACC:  ci_r <= (cc == 2'd3) ? 4'd0 : ci_r + 4'd1;
        S_V_PREP: st_r <= '0;
        S_V_DIV:  st_r <= st_r + SW'(1);
        S_V_EMIT: if (emit_go) ci_r <= ci_r + 4'd1;
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_LOAD: acc_r <= '0;
      S_T_LD1: begin
        opa_r  <= mat_rd_a;
        opb_r  <= {{(WB-E){mat_rd_b[E-1]}}, mat_rd_b};
        prod_r <= '0;
      end
      S_T_LD2: begin
        opa_r  <= mat_rd_a;
        opb_r  <= {{(WB-2*E){prod_r[2*E-1]}}, prod_r[2*E-1:0]};
        prod_r <= '0;
      end
      S_D_LD: begin
        opa_r  <= mat_rd_a;
        opb_r  <= {{(WB-C3W){cof_rd[C3W-1]}}, cof_rd};
        prod_r <= '0;
      end
      S_T_MUL1, S_T_MUL2, S_D_MUL: prod_r <= prod_r + pp_sh;
      S_T_ACC: acc_r <= term_neg ? acc_r - prod_r : acc_r + prod_r;
      S_C_WR:  acc_r <= '0;
      S_D_ACC: acc_r <= acc_r + prod_r;
      S_D_ABS: begin
        det_neg_r <= acc_r[AW-1];
        det_abs_r <= acc_r[AW-1] ? -acc_r : acc_r;
      end
      S_D_RND: begin
        det_val_r  <= det_val_c;
        det_clip_r <= det_clip_c;
        sing_r     <= sing_c;
      end
      S_V_PREP: begin
        rem_r <= x_c;
        dv_r  <= VW'(det_abs_r) << (E + 1);
        q_r   <= '0;
        neg_r <= cof_rd[C3W-1] ^ det_neg_r;
        ovf_r <= 1'b0;
      end
      S_V_DIV: begin
        if (ge) rem_r <= rem_r - dv_r;
        dv_r <= dv_r >> 1;
        if (st_r == '0) begin
          ovf_r <= ge;
        end else begin
          q_r <= {q_r[E-2:0], ge};
        end
      end
      default: ;
    endcase
    if (emit_go) begin
      out_elem_r <= res_val;
      out_idx_r  <= ci_r;
      out_last_r <= (ci_r == 4'd15);
      out_sing_r <= sing_r;
      out_sat_r  <= res_clip | det_clip_r;
      out_det_r  <= det_val_r;
    end
  end

  assign out_chan.valid             = out_valid_r;
  assign out_chan.inverse_element   = out_elem_r;
  assign out_chan.element_index     = out_idx_r;
  assign out_chan.last_result       = out_last_r;
  assign out_chan.singular          = out_sing_r;
  assign out_chan.saturated         = out_sat_r;
  assign out_chan.determinant_value = out_det_r;

endmodule

// ----- rtl/minv_checker.sv -----
// Port-level checks for the matrix inverse core, bound to its top level.
module minv_checker #(
  parameter int EW = minv_pkg::ELEMENT_WIDTH
) (
  input logic          clk,
  input logic          rst_n,
  input logic          out_valid,
  input logic          out_ready,
  input logic [EW-1:0] inverse_element,
  input logic [3:0]    element_index,
  input logic          last_result,
  input logic          singular,
  input logic [EW-1:0] determinant_value
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(inverse_element)
      && $stable(element_index) && $stable(determinant_value))
    else $error("result changed while stalled");

  // Last flag only on the final matrix position
  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (last_result == (element_index == 4'd15)))
    else $error("last_result does not match element_index");

  // A singular matrix yields all-zero elements
  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && singular |-> inverse_element == '0)
    else $error("nonzero element on singular matrix");

  // Consecutive results of one matrix step the index by one
  a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !last_result ##1 out_valid
      |-> element_index == $past(element_index) + 4'd1)
    else $error("element_index skipped");

endmodule

bind matrix_inverse_4x4_core minv_checker #(.EW(ELEMENT_WIDTH)) u_minv_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .inverse_element  (out_chan.inverse_element),
  .element_index    (out_chan.element_index),
  .last_result      (out_chan.last_result),
  .singular         (out_chan.singular),
  .determinant_value(out_chan.determinant_value)
);
